// File: src/numbered_notation_to_midi_parser_defines.svh
// Assertion macros shared by the checker.
`ifndef NUMBERED_NOTATION_TO_MIDI_PARSER_DEFINES_SVH
`define NUMBERED_NOTATION_TO_MIDI_PARSER_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define NN_ASSERT_IMP(label, ant, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error(msg);

// Implication checked in the cycle after the antecedent.
`define NN_ASSERT_NEXT(label, ant, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error(msg);

`endif

// File: src/nnmidi_pkg.sv
package nnmidi_pkg;

    localparam int TextW = 8;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_PLUS   = 4'd1,
        PH_MINUS  = 4'd2,
        PH_PITCH  = 4'd3,
        PH_MODS   = 4'd4,
        PH_SLASH  = 4'd5,
        PH_DOT    = 4'd6,
        PH_DASH   = 4'd7,
        PH_NTAIL  = 4'd8,
        PH_S_INT  = 4'd9,
        PH_S_FRAC = 4'd10,
        PH_S_TAIL = 4'd11,
        PH_V_NUM  = 4'd12,
        PH_V_TAIL = 4'd13,
        PH_T_NUM  = 4'd14,
        PH_T_TAIL = 4'd15
    } phase_t;

    typedef enum logic [1:0] {
        EV_NOTE  = 2'd0,
        EV_PROG  = 2'd1,
        EV_END   = 2'd2,
        EV_ERROR = 2'd3
    } event_kind_t;

    localparam logic [1:0] CFG_CHANNEL = 2'd0;
    localparam logic [1:0] CFG_VOLUME  = 2'd1;
    localparam logic [1:0] CFG_BEAT    = 2'd2;
    localparam logic [1:0] CFG_OCTAVE  = 2'd3;

    localparam logic [7:0] STATUS_NOTE = 8'h90;
    localparam logic [7:0] STATUS_PROG = 8'hC0;
    localparam logic [7:0] REST_CODE   = 8'd128;
    localparam logic [6:0] TOP_NOTE    = 7'h7F;
    localparam logic [23:0] FIELD24_MAX = 24'hFFFFFF;
    localparam logic [23:0] TEMPO_NUM  = 24'd6000000;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    typedef struct packed {
        logic        emit;
        event_kind_t kind;
        logic        start_div;
    } ctl_cmd_t;

    function automatic logic [3:0] degree_step(input logic [2:0] d);
        logic [3:0] r;
        case (d)
            3'd0: r = 4'd0;
            3'd1: r = 4'd2;
            3'd2: r = 4'd4;
            3'd3: r = 4'd5;
            3'd4: r = 4'd7;
            3'd5: r = 4'd9;
            3'd6: r = 4'd11;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

endpackage

// File: src/nnmidi_div.sv
module nnmidi_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [26:0] divisor,
    output logic [23:0] quotient,
    output nnmidi_pkg::div_status_t status
);
    import nnmidi_pkg::*;

    logic [23:0] rem_reg, rem_next;
    logic [23:0] quo_reg, quo_next;
    logic [26:0] dvs_reg, dvs_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [27:0] trial;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = '0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = TEMPO_NUM;
            dvs_next  = divisor;
            cnt_next  = 5'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            trial = {3'd0, rem_reg, quo_reg[23]} - {1'b0, dvs_reg};
            if (!trial[27])
            begin
                rem_next = trial[23:0];
                quo_next = {quo_reg[22:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[22:0], quo_reg[23]};
                quo_next = {quo_reg[22:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd23)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;
endmodule

// File: src/nnmidi_ctrl.sv
module nnmidi_ctrl (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        take,
    input  logic [7:0]  c,
    input  logic        div_needed,
    input  logic        div_busy,
    output nnmidi_pkg::phase_t phase,
    output logic        in_comment,
    output nnmidi_pkg::ctl_cmd_t cmd
);
    import nnmidi_pkg::*;

    phase_t phase_reg, phase_next;
    logic   com_reg, com_next;
    logic   digit, degree, blank, comma;

    always_comb
    begin
        digit  = (c >= "0") && (c <= "9");
        degree = (c >= "0") && (c <= "7");
        blank  = (c == " ") || (c == 8'h09) || (c == 8'h0A);
        comma  = (c == ",");
        phase_next = phase_reg;
        com_next   = com_reg;
        cmd        = '{emit: 1'b0, kind: EV_NOTE, start_div: 1'b0};
        if (take)
        begin
            if (com_reg)
            begin
                if (c == 8'h0A)
                begin
                    com_next = 1'b0;
                end
            end
            else if ((phase_reg <= PH_DASH) && blank)
            begin
                com_next = 1'b0;
            end
            else if ((phase_reg <= PH_DASH) && (c == "@"))
            begin
                com_next = 1'b1;
            end
            else
            begin
                case (phase_reg)
                    PH_IDLE:
                    begin
                        if (c == "$")
                        begin
                            cmd.emit = 1'b1;
                            cmd.kind = EV_END;
                        end
                        else if (c == "S")
                            phase_next = PH_S_INT;
                        else if (c == "V")
                            phase_next = PH_V_NUM;
                        else if (c == "T")
                            phase_next = PH_T_NUM;
                        else if (c == "+")
                            phase_next = PH_PLUS;
                        else if (c == "-")
                            phase_next = PH_MINUS;
                        else if (degree)
                            phase_next = (c == "0") ? PH_MODS : PH_PITCH;
                        else
                        begin
                            cmd.emit = 1'b1;
                            cmd.kind = EV_ERROR;
                        end
                    end
                    PH_PLUS, PH_MINUS:
                    begin
                        if (c == "+" && phase_reg == PH_PLUS)
                            phase_next = PH_PLUS;
                        else if (c == "-")
                            phase_next = PH_MINUS;
                        else if (degree)
                            phase_next = (c == "0") ? PH_MODS : PH_PITCH;
                        else
                        begin
                            cmd.emit   = 1'b1;
                            cmd.kind   = EV_ERROR;
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_PITCH, PH_MODS:
                    begin
                        if (comma)
                        begin
                            cmd.emit   = 1'b1;
                            cmd.kind   = EV_NOTE;
                            phase_next = PH_IDLE;
                        end
                        else if (c == "#" && phase_reg == PH_PITCH)
                            phase_next = PH_MODS;
                        else if (c == ".")
                            phase_next = PH_DOT;
                        else if (c == "/")
                            phase_next = PH_SLASH;
                        else if (c == "-")
                            phase_next = PH_DASH;
                        else
                            phase_next = PH_NTAIL;
                    end
                    PH_SLASH:
                    begin
                        if (comma)
                        begin
                            cmd.emit   = 1'b1;
                            phase_next = PH_IDLE;
                        end
                        else if (c == "/")
                            phase_next = PH_SLASH;
                        else if (c == "-")
                            phase_next = PH_DASH;
                        else
                            phase_next = PH_NTAIL;
                    end
                    PH_DOT, PH_DASH:
                    begin
                        if (comma)
                        begin
                            cmd.emit   = 1'b1;
                            phase_next = PH_IDLE;
                        end
                        else if (c == "-")
                            phase_next = PH_DASH;
                        else
                            phase_next = PH_NTAIL;
                    end
                    PH_NTAIL:
                    begin
                        if (comma)
                        begin
                            cmd.emit   = 1'b1;
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_S_INT:
                    begin
                        if (digit)
                            phase_next = PH_S_INT;
                        else if (c == ".")
                            phase_next = PH_S_FRAC;
                        else if (comma)
                        begin
                            cmd.start_div = div_needed;
                            phase_next    = PH_IDLE;
                        end
                        else
                            phase_next = PH_S_TAIL;
                    end
                    PH_S_FRAC:
                    begin
                        if (digit)
                            phase_next = PH_S_FRAC;
                        else if (comma)
                        begin
                            cmd.start_div = div_needed;
                            phase_next    = PH_IDLE;
                        end
                        else
                            phase_next = PH_S_TAIL;
                    end
                    PH_S_TAIL:
                    begin
                        if (comma)
                        begin
                            cmd.start_div = div_needed;
                            phase_next    = PH_IDLE;
                        end
                    end
                    PH_V_NUM:
                    begin
                        if (comma)
                            phase_next = PH_IDLE;
                        else if (!digit)
                            phase_next = PH_V_TAIL;
                    end
                    PH_V_TAIL:
                    begin
                        if (comma)
                            phase_next = PH_IDLE;
                    end
                    PH_T_NUM:
                    begin
                        if (comma)
                        begin
                            cmd.emit   = 1'b1;
                            cmd.kind   = EV_PROG;
                            phase_next = PH_IDLE;
                        end
                        else if (!digit)
                            phase_next = PH_T_TAIL;
                    end
                    PH_T_TAIL:
                    begin
                        if (comma)
                        begin
                            cmd.emit   = 1'b1;
                            cmd.kind   = EV_PROG;
                            phase_next = PH_IDLE;
                        end
                    end
                    default:
                        phase_next = PH_IDLE;
                endcase
                if (cmd.emit)
                    phase_next = PH_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            com_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            com_reg   <= com_next;
        end
    end

    assign phase      = phase_reg;
    assign in_comment = com_reg | div_busy;
endmodule

// File: src/nnmidi_dp.sv
module nnmidi_dp #(
    parameter int DurationBits = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        take,
    input  logic        com_active,
    input  logic [7:0]  c,
    input  nnmidi_pkg::phase_t phase,
    input  nnmidi_pkg::ctl_cmd_t cmd,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_idx,
    input  logic [23:0] cfg_data,
    input  logic [23:0] div_q,
    input  logic        div_done,
    output logic        div_needed,
    output logic [26:0] div_divisor,
    output logic [48:0] result
);
    import nnmidi_pkg::*;

    localparam logic [DurationBits-1:0] DurMax = '1;

    logic [3:0]  chan_reg;
    logic [3:0]  boct_reg;
    logic [23:0] beat_reg, beat_next;
    logic [6:0]  vol_reg, vol_next;
    logic [3:0]  oct_reg, oct_next;
    logic [3:0]  pofs_reg, pofs_next;
    logic        rest_reg, rest_next;
    logic [DurationBits-1:0] dur_reg, dur_next;
    logic [7:0]  dash_reg, dash_next;
    logic [23:0] cval_reg, cval_next;
    logic [1:0]  frac_reg, frac_next;

    logic        digit, degree, blank;
    logic [DurationBits:0] dsum, bsat;
    logic [27:0] acc;
    logic [7:0]  note;
    logic [23:0] dur_out;
    logic [30:0] scaled;

    always_comb
    begin
        digit  = (c >= "0") && (c <= "9");
        degree = (c >= "0") && (c <= "7");
        blank  = (c == " ") || (c == 8'h09) || (c == 8'h0A) || (c == "@");
        acc    = ({4'd0, cval_reg} << 3) + ({4'd0, cval_reg} << 1) + {24'd0, c[3:0] - 4'd0};
        if (DurationBits >= 24)
            bsat = {1'b0, DurationBits'(beat_reg)};
        else
            bsat = ((beat_reg >> DurationBits) != 24'd0) ? {1'b0, DurMax}
                                                         : {1'b0, DurationBits'(beat_reg)};
        dsum = '0;
        case (frac_reg)
            2'd0:    scaled = ({7'd0, cval_reg} << 6) + ({7'd0, cval_reg} << 5)
                              + ({7'd0, cval_reg} << 2);
            2'd1:    scaled = ({7'd0, cval_reg} << 3) + ({7'd0, cval_reg} << 1);
            default: scaled = {7'd0, cval_reg};
        endcase

        beat_next = beat_reg;
        vol_next  = vol_reg;
        oct_next  = oct_reg;
        pofs_next = pofs_reg;
        rest_next = rest_reg;
        dur_next  = dur_reg;
        dash_next = dash_reg;
        cval_next = cval_reg;
        frac_next = frac_reg;

        if (div_done)
            beat_next = div_q;
        if (take && !com_active && !((phase <= PH_DASH) && blank))
        begin
            if ((phase == PH_IDLE || phase == PH_PLUS || phase == PH_MINUS) && degree)
            begin
                dur_next  = bsat[DurationBits-1:0];
                dash_next = '0;
                rest_next = (c == "0");
                pofs_next = (c == "0") ? 4'd0 : degree_step(3'(c[2:0] - 3'd1));
            end
            case (phase)
                PH_IDLE:
                begin
                    cval_next = '0;
                    frac_next = '0;
                    if (c == "+")
                        oct_next = (boct_reg == 4'd15) ? boct_reg : boct_reg + 4'd1;
                    else if (c == "-")
                        oct_next = (boct_reg == 4'd0) ? boct_reg : boct_reg - 4'd1;
                    else if (c != "S" && c != "V" && c != "T" && c != "$")
                        oct_next = boct_reg;
                end
                PH_PLUS, PH_MINUS:
                begin
                    if (c == "+" && phase == PH_PLUS)
                        oct_next = (oct_reg == 4'd15) ? oct_reg : oct_reg + 4'd1;
                    else if (c == "-")
                        oct_next = (oct_reg == 4'd0) ? oct_reg : oct_reg - 4'd1;
                end
                default:
                begin
                end
            endcase
            if (phase == PH_PITCH && c == "#" && pofs_reg != 4'd4 && pofs_reg != 4'd11)
                pofs_next = pofs_reg + 4'd1;
            if ((phase == PH_PITCH || phase == PH_MODS) && c == ".")
            begin
                dsum     = {1'b0, dur_reg} + {2'b0, dur_reg[DurationBits-1:1]};
                dur_next = dsum[DurationBits] ? DurMax : dsum[DurationBits-1:0];
            end
            if ((phase == PH_PITCH || phase == PH_MODS || phase == PH_SLASH) && c == "/")
                dur_next = dur_reg >> 1;
            if ((phase >= PH_PITCH && phase <= PH_DASH) && c == "-")
            begin
                dash_next = (dash_reg == 8'd255) ? dash_reg : dash_reg + 8'd1;
                dsum      = {1'b0, dur_reg} + bsat;
                dur_next  = dsum[DurationBits] ? DurMax : dsum[DurationBits-1:0];
            end
            if (digit && (phase == PH_S_INT || phase == PH_V_NUM || phase == PH_T_NUM
                          || (phase == PH_S_FRAC && frac_reg != 2'd2)))
            begin
                cval_next = (acc > 28'(FIELD24_MAX)) ? FIELD24_MAX : acc[23:0];
                if (phase == PH_S_FRAC)
                    frac_next = frac_reg + 2'd1;
            end
            if ((phase == PH_V_NUM || phase == PH_V_TAIL) && c == "," && cval_reg != 24'd0)
                vol_next = (cval_reg > 24'd127) ? TOP_NOTE : cval_reg[6:0];
        end
        if (cfg_we && cfg_idx == CFG_VOLUME)
            vol_next = cfg_data[6:0];
        if (cfg_we && cfg_idx == CFG_BEAT)
            beat_next = cfg_data;

        note = ({4'd0, oct_reg} << 3) + ({4'd0, oct_reg} << 2) + {4'd0, pofs_reg};
        if (note > {1'b0, TOP_NOTE})
            note = {1'b0, TOP_NOTE};
        if (rest_reg)
            note = REST_CODE;
        if (DurationBits > 24 && (dur_reg >> 24) != '0)
            dur_out = FIELD24_MAX;
        else
            dur_out = 24'(dur_reg);
        case (cmd.kind)
            EV_NOTE:  result = {dur_out, vol_reg, note, STATUS_NOTE | {4'd0, chan_reg}, EV_NOTE};
            EV_PROG:  result = {24'd0, 7'd0,
                                (cval_reg > 24'd127) ? 8'd127 : {1'b0, cval_reg[6:0]},
                                STATUS_PROG | {4'd0, chan_reg}, EV_PROG};
            default:  result = {47'd0, cmd.kind};
        endcase
    end

    // A tempo value above the numerator gives a zero beat, so any larger divisor will do.
    assign div_divisor = (scaled > {7'd0, TEMPO_NUM}) ? {3'd0, TEMPO_NUM} + 27'd1
                                                      : scaled[26:0];
    assign div_needed  = (scaled != 31'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_reg <= 4'd4;
            boct_reg <= 4'd4;
            beat_reg <= 24'd500;
            vol_reg  <= 7'd127;
            oct_reg  <= 4'd4;
            pofs_reg <= '0;
            rest_reg <= 1'b0;
            dur_reg  <= '0;
            dash_reg <= '0;
            cval_reg <= '0;
            frac_reg <= '0;
        end
        else
        begin
            if (cfg_we && cfg_idx == CFG_CHANNEL)
                chan_reg <= cfg_data[3:0];
            if (cfg_we && cfg_idx == CFG_OCTAVE)
                boct_reg <= cfg_data[3:0];
            beat_reg <= beat_next;
            vol_reg  <= vol_next;
            oct_reg  <= oct_next;
            pofs_reg <= pofs_next;
            rest_reg <= rest_next;
            dur_reg  <= dur_next;
            dash_reg <= dash_next;
            cval_reg <= cval_next;
            frac_reg <= frac_next;
        end
    end
endmodule

// File: src/numbered_notation_to_midi_parser.sv
// A result appears on the output register in the cycle after its last byte is taken;
// throughput is one byte per cycle unless the output or the divider holds the input.
// A nonzero tempo ends in a 24-step restoring divide; input waits while it is busy or done.
// The output holds its result until taken; input is refused while it is full and not taken.
// Reset is asynchronous and active low; it restores all register and parser defaults.
module numbered_notation_to_midi_parser #(
    parameter int DURATION_BITS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // text_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // event_kind, status_byte, note_or_program, velocity,
                                   // duration_ms, zero pad
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    import nnmidi_pkg::*;

    logic        take;
    phase_t      phase;
    logic        com_active;
    ctl_cmd_t    cmd;
    logic        div_needed;
    logic [26:0] divisor;
    logic [23:0] quotient;
    div_status_t dstat;
    logic [48:0] result;
    logic        ov_reg;
    logic [48:0] od_reg;

    assign s_tready = (!ov_reg || m_tready) && !dstat.busy && !dstat.done;
    assign take     = s_tvalid && s_tready;

    nnmidi_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .take(take), .c(s_tdata),
        .div_needed(div_needed), .div_busy(1'b0),
        .phase(phase), .in_comment(com_active), .cmd(cmd)
    );

    nnmidi_dp #(.DurationBits(DURATION_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .take(take), .com_active(com_active), .c(s_tdata),
        .phase(phase), .cmd(cmd), .cfg_we(cfg_we), .cfg_idx(cfg_index),
        .cfg_data(cfg_data), .div_q(quotient), .div_done(dstat.done),
        .div_needed(div_needed), .div_divisor(divisor), .result(result)
    );

    nnmidi_div u_div (
        .clk(clk), .rst_n(rst_n), .start(cmd.start_div), .divisor(divisor),
        .quotient(quotient), .status(dstat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (take && cmd.emit)
            ov_reg <= 1'b1;
        else if (m_tready)
            ov_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take && cmd.emit)
            od_reg <= result;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {7'd0, od_reg};
endmodule

// File: src/nnmidi_checker.sv
`include "numbered_notation_to_midi_parser_defines.svh"
module nnmidi_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata
);
    import nnmidi_pkg::*;

    `NN_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output dropped")
    `NN_ASSERT_IMP(a_kind, m_tvalid && m_tdata[1:0] == EV_ERROR, m_tdata[49:2] == 48'd0, "bad error")
    `NN_ASSERT_IMP(a_stat, m_tvalid && m_tdata[1:0] == EV_NOTE, m_tdata[9:6] == STATUS_NOTE[7:4], "bad status")
    `NN_ASSERT_IMP(a_full, m_tvalid && !m_tready, !s_tready, "input taken while full")
endmodule

bind numbered_notation_to_midi_parser nnmidi_checker u_chk (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
